@@ rtl/hng_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hng_pkg - shared types and constants of the hysteresis noise gate
// Number formats, register map codes, datapath commands and controller states.
// ============================================================================
package hng_pkg;

    // sample and coefficient formats: Q1.23 samples, Q0.24 coefficients
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int THR_W       = SAMPLE_BITS - 1;

    // fixed detector filter coefficients, Q0.24
    localparam int HP_COEF = 216780;
    localparam int LP_COEF = 4952960;

    // internal widths
    localparam int TRK_W  = SAMPLE_BITS + 2;          // filter / envelope tracks
    localparam int DIFF_W = SAMPLE_BITS + 3;          // multiplier signed operand
    localparam int SUM_W  = DIFF_W + 1;               // track plus step
    localparam int MULA_W = COEF_BITS + 1;            // coefficient or Q1.24 gain
    localparam int PROD_W = MULA_W + 1 + DIFF_W;

    localparam logic [MULA_W-1:0] UNITY = MULA_W'(1) << COEF_BITS;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_GATE_ENABLE,
        REG_ENV_ATTACK,
        REG_ENV_RELEASE,
        REG_GAIN_ATTACK,
        REG_GAIN_RELEASE,
        REG_OPEN_THR,
        REG_CLOSE_THR
    } reg_idx_t;

    localparam logic [COEF_BITS-1:0] ENV_ATTACK_RST   = COEF_BITS'(231404);
    localparam logic [COEF_BITS-1:0] ENV_RELEASE_RST  = COEF_BITS'(1588);
    localparam logic [COEF_BITS-1:0] GAIN_ATTACK_RST  = COEF_BITS'(345960);
    localparam logic [COEF_BITS-1:0] GAIN_RELEASE_RST = COEF_BITS'(1942);
    localparam logic [THR_W-1:0]     OPEN_THR_RST     = THR_W'(8389);
    localparam logic [THR_W-1:0]     CLOSE_THR_RST    = THR_W'(3775);

    typedef struct packed {
        logic                 gate_enable;
        logic [COEF_BITS-1:0] env_attack;
        logic [COEF_BITS-1:0] env_release;
        logic [COEF_BITS-1:0] gain_attack;
        logic [COEF_BITS-1:0] gain_release;
        logic [THR_W-1:0]     open_thr;
        logic [THR_W-1:0]     close_thr;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HP_MUL,
        OP_HP_ACC,
        OP_LP_MUL,
        OP_LP_ACC,
        OP_MAG,
        OP_ENV_MUL,
        OP_ENV_ACC,
        OP_GAIN_MUL,
        OP_GAIN_ACC,
        OP_OUT_MUL,
        OP_OUT_ACC,
        OP_PASS
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic gate_enable;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HP_MUL,
        ST_HP_ACC,
        ST_LP_MUL,
        ST_LP_ACC,
        ST_MAG,
        ST_ENV_MUL,
        ST_ENV_ACC,
        ST_GAIN_MUL,
        ST_GAIN_ACC,
        ST_OUT_MUL,
        ST_OUT_ACC,
        ST_PASS
    } ctrl_state_t;

endpackage

@@ rtl/hysteresis_noise_gate_unit.sv @@
`timescale 1ns / 1ps
// Sequence: gate enabled, an accepted sample goes through 5 multiply-accumulates on
//   one shared 25x27 multiplier, each a multiply step and an accumulate step, plus
//   magnitude, into the output register; gate disabled, it passes straight there.
//   A new sample is accepted only once the previous one is stored; a full output stalls.
// Reset (rst_n, async, active low): filter tracks, envelope and gain cleared, gate
//   closed, registers at their defaults, no result pending.
// ============================================================================
// hysteresis_noise_gate_unit - noise gate with hysteresis envelope follower
// Sidechain high-pass/low-pass detector, attack/release envelope, open/close
// hysteresis and a smoothed gain applied to the audio sample.
// ============================================================================
module hysteresis_noise_gate_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [hng_pkg::ADDR_W-1:0]             paddr,
    input  logic [hng_pkg::DATA_W-1:0]             pwdata,
    output logic [hng_pkg::DATA_W-1:0]             prdata,
    output logic                                   pready,
    // input beat
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [hng_pkg::SAMPLE_BITS-1:0] sidechain_sample,
    input  logic signed [hng_pkg::SAMPLE_BITS-1:0] audio_sample,
    // result beat
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [hng_pkg::SAMPLE_BITS-1:0] gated_sample,
    output logic                                   gate_open
);
    import hng_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Register file. Writes are only expected while no sample is in flight,
    // so the datapath reads the live values directly.
    hng_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: accepts a beat in idle, then issues one datapath step per
    // cycle. The final step waits while the output register is still full,
    // so a result is never overwritten.
    hng_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: every one-pole update is a multiply step into the product
    // register followed by a round-and-accumulate step. The output register
    // holds the result until the downstream side takes it, while the next
    // sample may already be accepted and processed.
    hng_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .sidechain_sample (sidechain_sample),
        .audio_sample     (audio_sample),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .gated_sample     (gated_sample),
        .gate_open        (gate_open)
    );

endmodule

@@ rtl/hng_regs.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hng_regs - configuration register file
// APB-style slave, zero wait states; register i at byte address 4*i.
// ============================================================================
module hng_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hng_pkg::ADDR_W-1:0] paddr,
    input  logic [hng_pkg::DATA_W-1:0] pwdata,
    output logic [hng_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output hng_pkg::cfg_t              cfg
);
    import hng_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GATE_ENABLE:  cfg_next.gate_enable  = pwdata[0];
                REG_ENV_ATTACK:   cfg_next.env_attack   = pwdata[COEF_BITS-1:0];
                REG_ENV_RELEASE:  cfg_next.env_release  = pwdata[COEF_BITS-1:0];
                REG_GAIN_ATTACK:  cfg_next.gain_attack  = pwdata[COEF_BITS-1:0];
                REG_GAIN_RELEASE: cfg_next.gain_release = pwdata[COEF_BITS-1:0];
                REG_OPEN_THR:     cfg_next.open_thr     = pwdata[THR_W-1:0];
                REG_CLOSE_THR:    cfg_next.close_thr    = pwdata[THR_W-1:0];
                default:          cfg_next = cfg_reg;   // unmapped: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_enable  <= 1'b1;
            cfg_reg.env_attack   <= ENV_ATTACK_RST;
            cfg_reg.env_release  <= ENV_RELEASE_RST;
            cfg_reg.gain_attack  <= GAIN_ATTACK_RST;
            cfg_reg.gain_release <= GAIN_RELEASE_RST;
            cfg_reg.open_thr     <= OPEN_THR_RST;
            cfg_reg.close_thr    <= CLOSE_THR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_GATE_ENABLE:  prdata = DATA_W'(cfg_reg.gate_enable);
            REG_ENV_ATTACK:   prdata = DATA_W'(cfg_reg.env_attack);
            REG_ENV_RELEASE:  prdata = DATA_W'(cfg_reg.env_release);
            REG_GAIN_ATTACK:  prdata = DATA_W'(cfg_reg.gain_attack);
            REG_GAIN_RELEASE: prdata = DATA_W'(cfg_reg.gain_release);
            REG_OPEN_THR:     prdata = DATA_W'(cfg_reg.open_thr);
            REG_CLOSE_THR:    prdata = DATA_W'(cfg_reg.close_thr);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ rtl/hng_dp.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hng_dp - noise gate datapath
// Filter, envelope and gain state, one shared multiplier, output register.
// ============================================================================
module hng_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hng_pkg::cfg_t                        cfg,
    input  hng_pkg::dp_cmd_t                     cmd,
    output hng_pkg::dp_status_t                  status,
    input  logic signed [hng_pkg::SAMPLE_BITS-1:0] sidechain_sample,
    input  logic signed [hng_pkg::SAMPLE_BITS-1:0] audio_sample,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [hng_pkg::SAMPLE_BITS-1:0] gated_sample,
    output logic                                 gate_open
);
    import hng_pkg::*;

    localparam logic signed [63:0] S_MAX64 = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] S_MIN64 = -(64'sd1 <<< (SAMPLE_BITS - 1));
    localparam logic signed [PROD_W-1:0] P_SMAX = PROD_W'(S_MAX64);
    localparam logic signed [PROD_W-1:0] P_SMIN = PROD_W'(S_MIN64);
    localparam logic signed [TRK_W-1:0]  T_SMAX = TRK_W'(S_MAX64);
    localparam logic signed [TRK_W-1:0]  T_SMIN = TRK_W'(S_MIN64);
    localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1) <<< (COEF_BITS - 1);

    // detector state
    logic signed [TRK_W-1:0]  hpt_reg, hpt_next;
    logic signed [TRK_W-1:0]  lpt_reg, lpt_next;
    logic signed [TRK_W-1:0]  env_reg, env_next;
    logic [MULA_W-1:0]        gain_reg, gain_next;
    logic                     flag_reg, flag_next;
    logic                     out_valid_reg, out_valid_next;

    // payload
    logic signed [SAMPLE_BITS-1:0] sc_reg, audio_reg;
    logic signed [TRK_W-1:0]       mag_reg;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] gated_reg, gated_next;
    logic                          open_reg;

    logic [MULA_W-1:0]        mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0] step_full;
    logic signed [DIFF_W-1:0] step;
    logic signed [TRK_W-1:0]  hp_val;
    logic signed [SUM_W-1:0]  hpt_sum, lpt_sum, env_sum, gain_sum;
    logic signed [TRK_W-1:0]  gain_s;
    logic signed [SUM_W-1:0]  open_s, close_s, unity_s;
    logic                     out_load;
    logic                     mul_en;

    // round to nearest, ties up: add half LSB, arithmetic shift is a floor
    assign prod_rnd  = prod_reg + HALF;
    assign step_full = prod_rnd >>> COEF_BITS;
    assign step      = step_full[DIFF_W-1:0];

    assign hp_val  = TRK_W'(sc_reg) - hpt_reg;
    assign gain_s  = $signed(TRK_W'(gain_reg));
    assign hpt_sum = SUM_W'(hpt_reg) + SUM_W'(step);
    assign lpt_sum = SUM_W'(lpt_reg) + SUM_W'(step);
    assign env_sum = SUM_W'(env_reg) + SUM_W'(step);
    assign gain_sum = SUM_W'(gain_s) + SUM_W'(step);
    assign open_s  = $signed(SUM_W'(cfg.open_thr));
    assign close_s = $signed(SUM_W'(cfg.close_thr));
    assign unity_s = $signed(SUM_W'(UNITY));

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        case (cmd.op)
            OP_HP_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MULA_W'(HP_COEF);
                mul_b  = DIFF_W'(sc_reg) - DIFF_W'(hpt_reg);
            end
            OP_LP_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MULA_W'(LP_COEF);
                mul_b  = DIFF_W'(hp_val) - DIFF_W'(lpt_reg);
            end
            OP_ENV_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = (mag_reg > env_reg) ? MULA_W'(cfg.env_attack)
                                             : MULA_W'(cfg.env_release);
                mul_b  = DIFF_W'(mag_reg) - DIFF_W'(env_reg);
            end
            OP_GAIN_MUL:
            begin
                mul_en = 1'b1;
                // target 1.0 when open, 0 when closed; rises only toward 1.0
                mul_a  = (flag_reg && (gain_reg < UNITY)) ? MULA_W'(cfg.gain_attack)
                                                          : MULA_W'(cfg.gain_release);
                mul_b  = flag_reg ? (DIFF_W'($signed({1'b0, UNITY})) - DIFF_W'(gain_s))
                                  : -DIFF_W'(gain_s);
            end
            OP_OUT_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = gain_reg;
                mul_b  = DIFF_W'(audio_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod_next = $signed({1'b0, mul_a}) * mul_b;

    // state updates
    always_comb
    begin
        hpt_next   = hpt_reg;
        lpt_next   = lpt_reg;
        env_next   = env_reg;
        gain_next  = gain_reg;
        flag_next  = flag_reg;
        gated_next = gated_reg;
        out_load   = 1'b0;
        case (cmd.op)
            OP_HP_ACC:  hpt_next = hpt_sum[TRK_W-1:0];
            OP_LP_ACC:  lpt_next = lpt_sum[TRK_W-1:0];
            OP_ENV_ACC:
            begin
                env_next = env_sum[TRK_W-1:0];
                if (!flag_reg)
                    flag_next = (env_sum >= open_s);
                else
                    flag_next = !(env_sum < close_s);
            end
            OP_GAIN_ACC:
            begin
                priority if (gain_sum > unity_s)
                    gain_next = UNITY;
                else if (gain_sum < 0)
                    gain_next = '0;
                else
                    gain_next = gain_sum[MULA_W-1:0];
            end
            OP_OUT_ACC:
            begin
                out_load = 1'b1;
                priority if (step_full > P_SMAX)
                    gated_next = P_SMAX[SAMPLE_BITS-1:0];
                else if (step_full < P_SMIN)
                    gated_next = P_SMIN[SAMPLE_BITS-1:0];
                else
                    gated_next = step_full[SAMPLE_BITS-1:0];
            end
            OP_PASS:
            begin
                out_load   = 1'b1;
                gated_next = audio_reg;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg & ~out_ready) | out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpt_reg       <= '0;
            lpt_reg       <= '0;
            env_reg       <= '0;
            gain_reg      <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hpt_reg       <= hpt_next;
            lpt_reg       <= lpt_next;
            env_reg       <= env_next;
            gain_reg      <= gain_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            sc_reg    <= sidechain_sample;
            audio_reg <= audio_sample;
        end
        if (cmd.op == OP_MAG)
            mag_reg <= lpt_reg[TRK_W-1] ? -lpt_reg : lpt_reg;
        if (mul_en)
            prod_reg <= prod_next;
        if (out_load)
        begin
            gated_reg <= gated_next;
            open_reg  <= flag_reg;
        end
    end

    assign status.gate_enable = cfg.gate_enable;
    assign status.out_free    = ~out_valid_reg | out_ready;
    assign out_valid    = out_valid_reg;
    assign gated_sample = gated_reg;
    assign gate_open    = open_reg;

    // gain stays within [0, 1.0]
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= UNITY)
        else $error("smoothed gain above unity");

    // envelope is a magnitude follower and never goes negative
    a_env_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !env_reg[TRK_W-1])
        else $error("envelope negative");

    // high-pass track stays within the sample range
    a_hpt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hpt_reg <= T_SMAX) && (hpt_reg >= T_SMIN))
        else $error("high-pass track out of sample range");

    // a finished sample lands in the output register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT_ACC || cmd.op == OP_PASS) |=> out_valid_reg)
        else $error("result not registered");

endmodule

@@ rtl/hng_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hng_ctrl - noise gate sequencer
// Walks one sample through the datapath steps, one command per cycle.
// ============================================================================
module hng_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hng_pkg::dp_status_t status,
    output hng_pkg::dp_cmd_t    cmd
);
    import hng_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.gate_enable ? ST_HP_MUL : ST_PASS;
            end
            ST_HP_MUL:   state_next = ST_HP_ACC;
            ST_HP_ACC:   state_next = ST_LP_MUL;
            ST_LP_MUL:   state_next = ST_LP_ACC;
            ST_LP_ACC:   state_next = ST_MAG;
            ST_MAG:      state_next = ST_ENV_MUL;
            ST_ENV_MUL:  state_next = ST_ENV_ACC;
            ST_ENV_ACC:  state_next = ST_GAIN_MUL;
            ST_GAIN_MUL: state_next = ST_GAIN_ACC;
            ST_GAIN_ACC: state_next = ST_OUT_MUL;
            ST_OUT_MUL:  state_next = ST_OUT_ACC;
            ST_OUT_ACC,
            ST_PASS:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            ST_HP_MUL:   cmd.op = OP_HP_MUL;
            ST_HP_ACC:   cmd.op = OP_HP_ACC;
            ST_LP_MUL:   cmd.op = OP_LP_MUL;
            ST_LP_ACC:   cmd.op = OP_LP_ACC;
            ST_MAG:      cmd.op = OP_MAG;
            ST_ENV_MUL:  cmd.op = OP_ENV_MUL;
            ST_ENV_ACC:  cmd.op = OP_ENV_ACC;
            ST_GAIN_MUL: cmd.op = OP_GAIN_MUL;
            ST_GAIN_ACC: cmd.op = OP_GAIN_ACC;
            ST_OUT_MUL:  cmd.op = OP_OUT_MUL;
            ST_OUT_ACC:  cmd.op = status.out_free ? OP_OUT_ACC : OP_NONE;
            ST_PASS:     cmd.op = status.out_free ? OP_PASS : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule
